/* sv/dshot_frame_waveform_encoder_macros.svh */
// ----------------------------------------------------------------------------
// DShot encoder assertion macros
// Clocked, reset-qualified property wrappers for the encoder checks.
// ----------------------------------------------------------------------------
`ifndef DSHOT_FRAME_WAVEFORM_ENCODER_MACROS_SVH
`define DSHOT_FRAME_WAVEFORM_ENCODER_MACROS_SVH

// same-cycle implication
`define DSHOT_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("dshot encoder check failed");

// next-cycle implication
`define DSHOT_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("dshot encoder check failed");

`endif

/* sv/dshot_pkg.sv */
// ----------------------------------------------------------------------------
// DShot encoder package
// Shared constants, register codes, structs and the frame builder.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package dshot_pkg;

    localparam int DATA_SLOTS  = 32;
    localparam int GAP_SLOTS   = 2;
    localparam int TOTAL_SLOTS = DATA_SLOTS + GAP_SLOTS;

    localparam int VALUE_W = 32;
    localparam int FRAME_W = 32;
    localparam int FIDX_W  = $clog2(FRAME_W);
    localparam int SLOT_W  = $clog2(TOTAL_SLOTS);
    localparam int TICK_W  = 6;

    localparam int APB_DW  = 32;
    localparam int APB_AW  = 4;
    localparam int RIDX_W  = APB_AW - 2;

    localparam logic [TICK_W-1:0] PERIOD_TOP_RST = 6'd20;
    localparam logic [TICK_W-1:0] ONE_HIGH_RST   = 6'd14;
    localparam logic [TICK_W-1:0] ZERO_HIGH_RST  = 6'd7;

    typedef enum logic [RIDX_W-1:0] {
        REG_PERIOD_TOP = 2'd0,
        REG_ONE_HIGH   = 2'd1,
        REG_ZERO_HIGH  = 2'd2
    } t_reg_idx;

    typedef struct packed {
        logic [TICK_W-1:0] period_top;
        logic [TICK_W-1:0] one_high_ticks;
        logic [TICK_W-1:0] zero_high_ticks;
    } t_cfg;

    typedef struct packed {
        logic done;
        logic refused;
        logic busy;
        logic level;
    } t_result;

    // value low 24 bits in the top, XOR of the four bytes in the low byte
    function automatic logic [FRAME_W-1:0] build_frame(input logic [VALUE_W-1:0] v);
        logic [7:0] sum;
        sum = v[7:0] ^ v[15:8] ^ v[23:16] ^ v[31:24];
        return {v[23:0], sum};
    endfunction

endpackage

/* sv/dshot_regs.sv */
// ----------------------------------------------------------------------------
// DShot encoder register file
// APB slave holding slot period and high-time registers.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module dshot_regs import dshot_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [APB_AW-1:0] paddr,
    input  logic [APB_DW-1:0] pwdata,
    output logic [APB_DW-1:0] prdata,
    output logic              pready,
    output t_cfg              o_cfg
);

    t_cfg  r_cfg;
    t_cfg  n_cfg;
    logic  w_wr;
    logic [RIDX_W-1:0] w_idx;

    assign pready = 1'b1;
    assign w_wr   = psel & penable & pwrite;
    assign w_idx  = paddr[APB_AW-1:2];

    always_comb begin
        n_cfg = r_cfg;
        if (w_wr) begin
            case (w_idx)
                REG_PERIOD_TOP: n_cfg.period_top      = pwdata[TICK_W-1:0];
                REG_ONE_HIGH:   n_cfg.one_high_ticks  = pwdata[TICK_W-1:0];
                REG_ZERO_HIGH:  n_cfg.zero_high_ticks = pwdata[TICK_W-1:0];
                default:        n_cfg = r_cfg;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.period_top      <= PERIOD_TOP_RST;
            r_cfg.one_high_ticks  <= ONE_HIGH_RST;
            r_cfg.zero_high_ticks <= ZERO_HIGH_RST;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    always_comb begin
        case (w_idx)
            REG_PERIOD_TOP: prdata = APB_DW'(r_cfg.period_top);
            REG_ONE_HIGH:   prdata = APB_DW'(r_cfg.one_high_ticks);
            REG_ZERO_HIGH:  prdata = APB_DW'(r_cfg.zero_high_ticks);
            default:        prdata = '0;
        endcase
    end

    assign o_cfg = r_cfg;

endmodule

/* sv/dshot_slot_gen.sv */
// ----------------------------------------------------------------------------
// DShot slot generator
// Frame, slot and tick state; produces one line sample per tick.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module dshot_slot_gen import dshot_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_step,
    input  logic               i_start,
    input  logic [FRAME_W-1:0] i_frame,
    input  t_cfg               i_cfg,
    output t_result            o_res,
    output logic               o_sending
);

    logic [FRAME_W-1:0] r_frame;
    logic [FRAME_W-1:0] n_frame;
    logic [SLOT_W-1:0]  r_slot;
    logic [SLOT_W-1:0]  n_slot;
    logic [TICK_W-1:0]  r_tick;
    logic [TICK_W-1:0]  n_tick;
    logic               r_sending;
    logic               n_sending;

    logic               w_take;
    logic [FRAME_W-1:0] w_frame;
    logic [SLOT_W-1:0]  w_slot;
    logic [TICK_W-1:0]  w_tick;
    logic               w_active;
    logic               w_bit;
    logic [TICK_W-1:0]  w_high;
    logic               w_slot_end;
    logic               w_last;

    // a start while idle loads the frame and begins slot 0 on the same tick
    assign w_take   = i_start & ~r_sending;
    assign w_frame  = w_take ? i_frame : r_frame;
    assign w_slot   = w_take ? '0 : r_slot;
    assign w_tick   = w_take ? '0 : r_tick;
    assign w_active = r_sending | i_start;

    assign w_bit      = w_frame[FIDX_W'(w_slot)];
    assign w_high     = w_bit ? i_cfg.one_high_ticks : i_cfg.zero_high_ticks;
    assign w_slot_end = w_active & (w_tick >= i_cfg.period_top);
    assign w_last     = (w_slot >= SLOT_W'(TOTAL_SLOTS - 1));

    always_comb begin
        o_res.level   = w_active & (int'(w_slot) < DATA_SLOTS) & (w_tick < w_high);
        o_res.busy    = w_active;
        o_res.refused = i_start & r_sending;
        o_res.done    = w_slot_end & w_last;
    end

    always_comb begin
        n_frame   = w_frame;
        n_slot    = w_slot;
        n_tick    = w_tick;
        n_sending = w_active;
        if (w_active) begin
            if (w_slot_end) begin
                n_tick = '0;
                if (w_last) begin
                    n_slot    = '0;
                    n_sending = 1'b0;
                end else begin
                    n_slot = w_slot + 1'b1;
                end
            end else begin
                n_tick = w_tick + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_slot    <= '0;
            r_tick    <= '0;
            r_sending <= 1'b0;
        end else if (i_step) begin
            r_slot    <= n_slot;
            r_tick    <= n_tick;
            r_sending <= n_sending;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_step) begin
            r_frame <= n_frame;
        end
    end

    assign o_sending = r_sending;

endmodule

/* sv/dshot_frame_waveform_encoder.sv */
// ----------------------------------------------------------------------------
// DShot frame waveform encoder
// Per-tick motor line encoder: 32 data slots LSB first, then two low gap slots.
//
//   Channel  Dir  Beat contents
//   s_axis   in   tuser: start_req; tdata: frame_value
//   m_axis   out  tdata: line_level, busy_res, start_refused; tlast: frame_done
//   apb      cfg  0x0 period_top, 0x4 one_high_ticks, 0x8 zero_high_ticks
//
// One tick per cycle while the output is not stalled; an input beat passes
// through the input register, then slot logic into the result register.
// The frame/slot/tick state advances only when the input register moves on.
// Output stalls hold the result register; one more beat is taken into the
// input register meanwhile. Synchronous active-low reset, no clearing pass.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "dshot_frame_waveform_encoder_macros.svh"

module dshot_frame_waveform_encoder import dshot_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               s_axis_tvalid,
    output logic               s_axis_tready,
    input  logic [VALUE_W-1:0] s_axis_tdata,   // [31:0] frame_value
    input  logic               s_axis_tuser,   // [0] start_req
    output logic               m_axis_tvalid,
    input  logic               m_axis_tready,
    output logic [7:0]         m_axis_tdata,   // [0] line_level, [1] busy_res,
                                               // [2] start_refused, [7:3] zero
    output logic               m_axis_tlast,   // frame_done
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [APB_AW-1:0]  paddr,
    input  logic [APB_DW-1:0]  pwdata,
    output logic [APB_DW-1:0]  prdata,
    output logic               pready
);

    t_cfg               w_cfg;
    logic               r_in_valid;
    logic               r_in_start;
    logic [FRAME_W-1:0] r_in_frame;
    logic               r_out_valid;
    t_result            r_out;
    t_result            w_res;
    logic               w_adv;
    logic               w_step;
    logic               w_take_in;
    logic               w_sending;

    dshot_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (w_cfg)
    );

    // result register free or draining this cycle
    assign w_adv         = ~r_out_valid | m_axis_tready;
    assign w_step        = r_in_valid & w_adv;
    assign s_axis_tready = ~r_in_valid | w_adv;
    assign w_take_in     = s_axis_tvalid & s_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (s_axis_tready) begin
            r_in_valid <= s_axis_tvalid;
        end
    end

    // checksum folded in on capture
    always_ff @(posedge i_clk) begin
        if (w_take_in) begin
            r_in_start <= s_axis_tuser;
            r_in_frame <= build_frame(s_axis_tdata);
        end
    end

    dshot_slot_gen u_slot_gen (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_step    (w_step),
        .i_start   (r_in_start),
        .i_frame   (r_in_frame),
        .i_cfg     (w_cfg),
        .o_res     (w_res),
        .o_sending (w_sending)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_adv) begin
            r_out_valid <= r_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_step) begin
            r_out <= w_res;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {5'b0, r_out.refused, r_out.busy, r_out.level};
    assign m_axis_tlast  = r_out.done;

    `DSHOT_ASSERT_NXT(a_done_goes_idle, i_clk, i_rst_n, w_step && w_res.done, !w_sending)
    `DSHOT_ASSERT_NXT(a_start_goes_busy, i_clk, i_rst_n,
                      w_step && r_in_start && !w_sending, w_sending)
    `DSHOT_ASSERT_IMP(a_refuse_only_busy, i_clk, i_rst_n, w_step && w_res.refused, w_sending)
    `DSHOT_ASSERT_NXT(a_hold_no_step, i_clk, i_rst_n, !w_step, $stable(w_sending))

endmodule
